// File: hdl/spce_pkg.sv
package spce_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CHANNELS    = 2;
    localparam int ENV_SHIFT   = 32 - SAMPLE_BITS;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // 20*log10(2) in Q16, log2(10)/20 in Q24, and the 2^f polynomial in Q1.30.
    localparam logic [31:0] DB_PER_LOG2 = 32'd394566;
    localparam logic [31:0] LOG2_PER_DB = 32'd2786635;
    localparam logic [31:0] EXP_A       = 32'd747394793;
    localparam logic [31:0] EXP_B       = 32'd241048950;
    localparam logic [31:0] EXP_C       = 32'd85298081;
    localparam logic [31:0] ONE_Q30     = 32'd1073741824;

    typedef enum logic [2:0] {
        CFG_UNITY     = 3'd0,
        CFG_THRESHOLD = 3'd1,
        CFG_IHIGH     = 3'd2,
        CFG_ILOW      = 3'd3,
        CFG_ALPHA     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] unity_db;
        logic signed [16:0] threshold_db;
        logic [22:0]        inv_ratio_high;
        logic [22:0]        inv_ratio_low;
        logic [23:0]        decay_alpha;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_a;
        logic signed [SAMPLE_BITS-1:0] sample_b;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_a;
        logic signed [SAMPLE_BITS-1:0] out_b;
    } t_out_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PEAK,
        S_DECAY,
        S_STORE,
        S_NORM,
        S_LOG_MUL,
        S_LOG_USE,
        S_DB_MUL,
        S_DB_USE,
        S_T1_MUL,
        S_T1_USE,
        S_T2_MUL,
        S_T2_USE,
        S_E_MUL,
        S_E_USE,
        S_GAIN,
        S_POLY_MUL,
        S_POLY_USE,
        S_MAG_MUL,
        S_MAG_RND,
        S_SAT,
        S_NEXT,
        S_DONE
    } t_state;

    // Rounds p / 2^sh half up; p is a magnitude, so this is half away from zero.
    function automatic logic [63:0] f_round(input logic [63:0] p, input logic [5:0] sh);
        logic [63:0] half;
        half = 64'd1 << (sh - 6'd1);
        return (p + half) >> sh;
    endfunction

    function automatic logic signed [39:0] f_sround(input logic [63:0] p,
                                                    input logic [5:0] sh,
                                                    input logic neg);
        logic [63:0]        m;
        logic signed [39:0] r;
        m = f_round(p, sh);
        r = $signed(m[39:0]);
        return neg ? -r : r;
    endfunction

    function automatic logic [39:0] f_mag40(input logic signed [39:0] v);
        return v[39] ? 40'(-v) : 40'(v);
    endfunction

endpackage

// File: hdl/spce_mul.sv
module spce_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: hdl/spce_core.sv
module spce_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spce_pkg::t_cfg    i_cfg,
    input  logic              i_start,
    input  spce_pkg::t_in_req i_req,
    input  logic              i_take,
    output logic              o_idle,
    output logic              o_done,
    output spce_pkg::t_out_req o_res
);

    localparam int SB = spce_pkg::SAMPLE_BITS;
    localparam int CH = spce_pkg::CHANNELS;
    localparam int CW = spce_pkg::CH_W;
    localparam logic [63:0] SAT_HI = 64'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [39:0] E_HUGE = 40'(SB * 65536);
    localparam logic signed [39:0] E_TINY = -40'sd2097152;

    spce_pkg::t_state r_state, n_state;

    logic signed [SB-1:0] r_x[CH], n_x[CH];
    logic signed [SB-1:0] r_prev[CH], n_prev[CH];
    logic [31:0]          r_envs[CH], n_envs[CH];
    logic signed [SB-1:0] r_out[CH], n_out[CH];
    logic [CW-1:0]        r_ch, n_ch;

    logic [31:0]          r_env, n_env;
    logic [31:0]          r_m, n_m;
    logic [4:0]           r_k, n_k;
    logic [15:0]          r_frac, n_frac;
    logic [3:0]           r_cnt, n_cnt;
    logic signed [17:0]   r_db, n_db;
    logic                 r_low, n_low;
    logic                 r_neg, n_neg;
    logic signed [39:0]   r_g, n_g;
    logic signed [39:0]   r_e, n_e;
    logic [31:0]          r_poly, n_poly;
    logic [63:0]          r_acc, n_acc;
    logic signed [SB-1:0] r_y, n_y;

    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_prod;

    spce_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spce_pkg::S_IDLE;
            r_ch    <= '0;
            for (int c = 0; c < CH; c++) begin
                r_prev[c] <= '0;
                r_envs[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_prev  <= n_prev;
            r_envs  <= n_envs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_out  <= n_out;
        r_env  <= n_env;
        r_m    <= n_m;
        r_k    <= n_k;
        r_frac <= n_frac;
        r_cnt  <= n_cnt;
        r_db   <= n_db;
        r_low  <= n_low;
        r_neg  <= n_neg;
        r_g    <= n_g;
        r_e    <= n_e;
        r_poly <= n_poly;
        r_acc  <= n_acc;
        r_y    <= n_y;
    end

    always_comb begin
        logic signed [SB-1:0] x, pv;
        logic signed [SB:0]   sum;
        logic [SB-1:0]        ax;
        logic [SB:0]          as;
        logic [33:0]          pk2w;
        logic [31:0]          pk1, pk2, peak, env;
        logic [32:0]          sq;
        logic [5:0]           kd, sh;
        logic signed [21:0]   lval;
        logic signed [39:0]   v, sv, un, thr, db;
        logic [31:0]          coef;

        n_state = r_state;
        n_x     = r_x;
        n_prev  = r_prev;
        n_envs  = r_envs;
        n_out   = r_out;
        n_ch    = r_ch;
        n_env   = r_env;
        n_m     = r_m;
        n_k     = r_k;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_db    = r_db;
        n_low   = r_low;
        n_neg   = r_neg;
        n_g     = r_g;
        n_e     = r_e;
        n_poly  = r_poly;
        n_acc   = r_acc;
        n_y     = r_y;
        w_mul_a = '0;
        w_mul_b = '0;

        x    = r_x[r_ch];
        pv   = r_prev[r_ch];
        env  = r_envs[r_ch];
        sum  = (SB+1)'(x) + (SB+1)'(pv);
        ax   = x[SB-1] ? SB'(-x) : SB'(x);
        as   = sum[SB] ? (SB+1)'(-sum) : (SB+1)'(sum);
        pk1  = 32'(ax) << spce_pkg::ENV_SHIFT;
        pk2w = (34'(as) << spce_pkg::ENV_SHIFT) >> 1;
        pk2  = pk2w[31:0];
        peak = (pk2 > pk1) ? pk2 : pk1;
        sq   = w_prod[63:31];
        kd   = 6'({1'b0, r_k}) - 6'd31;
        lval = $signed({kd, r_frac});
        un   = 40'(i_cfg.unity_db);
        thr  = 40'(i_cfg.threshold_db);
        db   = 40'(r_db);
        v    = '0;
        sv   = '0;
        sh   = 6'd30 - r_e[21:16];
        coef = spce_pkg::ONE_Q30;

        unique case (r_state)
            spce_pkg::S_IDLE: begin
                if (i_start) begin
                    n_x[0]  = i_req.sample_a;
                    n_x[1]  = i_req.sample_b;
                    n_ch    = '0;
                    n_state = spce_pkg::S_PEAK;
                end
            end
            spce_pkg::S_PEAK: begin
                if (peak > env) begin
                    n_env   = peak;
                    n_state = spce_pkg::S_STORE;
                end else begin
                    n_env   = env;
                    w_mul_a = env - peak;
                    w_mul_b = 32'(i_cfg.decay_alpha);
                    n_state = spce_pkg::S_DECAY;
                end
            end
            spce_pkg::S_DECAY: begin
                n_env   = r_env - w_prod[55:24];
                n_state = spce_pkg::S_STORE;
            end
            spce_pkg::S_STORE: begin
                n_envs[r_ch] = r_env;
                n_prev[r_ch] = x;
                if (r_env < (32'd1 << spce_pkg::ENV_SHIFT)) begin
                    n_y     = '0;
                    n_state = spce_pkg::S_NEXT;
                end else begin
                    n_m     = r_env;
                    n_k     = 5'd31;
                    n_state = spce_pkg::S_NORM;
                end
            end
            spce_pkg::S_NORM: begin
                if (r_m[31]) begin
                    n_frac  = '0;
                    n_cnt   = '0;
                    n_state = spce_pkg::S_LOG_MUL;
                end else begin
                    n_m = r_m << 1;
                    n_k = r_k - 5'd1;
                end
            end
            spce_pkg::S_LOG_MUL: begin
                w_mul_a = r_m;
                w_mul_b = r_m;
                n_state = spce_pkg::S_LOG_USE;
            end
            spce_pkg::S_LOG_USE: begin
                n_m    = sq[32] ? sq[32:1] : sq[31:0];
                n_frac = {r_frac[14:0], sq[32]};
                n_cnt  = r_cnt + 4'd1;
                n_state = (r_cnt == 4'd15) ? spce_pkg::S_DB_MUL : spce_pkg::S_LOG_MUL;
            end
            spce_pkg::S_DB_MUL: begin
                v       = 40'(lval);
                w_mul_a = 32'(spce_pkg::f_mag40(v));
                w_mul_b = spce_pkg::DB_PER_LOG2;
                n_neg   = v[39];
                n_state = spce_pkg::S_DB_USE;
            end
            spce_pkg::S_DB_USE: begin
                sv      = spce_pkg::f_sround(w_prod, 6'd24, r_neg);
                n_db    = sv[17:0];
                n_low   = (sv <= thr);
                n_state = spce_pkg::S_T1_MUL;
            end
            spce_pkg::S_T1_MUL: begin
                v       = r_low ? (thr - un) : (db - un);
                w_mul_a = 32'(spce_pkg::f_mag40(v));
                w_mul_b = 32'(i_cfg.inv_ratio_high);
                n_neg   = v[39];
                n_state = spce_pkg::S_T1_USE;
            end
            spce_pkg::S_T1_USE: begin
                sv      = spce_pkg::f_sround(w_prod, 6'd16, r_neg);
                n_g     = un + sv - db;
                n_state = r_low ? spce_pkg::S_T2_MUL : spce_pkg::S_E_MUL;
            end
            spce_pkg::S_T2_MUL: begin
                v       = db - thr;
                w_mul_a = 32'(spce_pkg::f_mag40(v));
                w_mul_b = 32'(i_cfg.inv_ratio_low);
                n_neg   = v[39];
                n_state = spce_pkg::S_T2_USE;
            end
            spce_pkg::S_T2_USE: begin
                n_g     = r_g + spce_pkg::f_sround(w_prod, 6'd16, r_neg);
                n_state = spce_pkg::S_E_MUL;
            end
            spce_pkg::S_E_MUL: begin
                w_mul_a = 32'(spce_pkg::f_mag40(r_g));
                w_mul_b = spce_pkg::LOG2_PER_DB;
                n_neg   = r_g[39];
                n_state = spce_pkg::S_E_USE;
            end
            spce_pkg::S_E_USE: begin
                n_e     = spce_pkg::f_sround(w_prod, 6'd16, r_neg);
                n_state = spce_pkg::S_GAIN;
            end
            spce_pkg::S_GAIN: begin
                if (x == '0) begin
                    n_y     = '0;
                    n_state = spce_pkg::S_NEXT;
                end else if (r_e >= E_HUGE) begin
                    n_y     = x[SB-1] ? SB'(SAT_HI + 64'd1) : SB'(SAT_HI);
                    n_state = spce_pkg::S_NEXT;
                end else begin
                    n_e     = (r_e < E_TINY) ? E_TINY : r_e;
                    n_poly  = spce_pkg::EXP_C;
                    n_cnt   = '0;
                    n_state = spce_pkg::S_POLY_MUL;
                end
            end
            spce_pkg::S_POLY_MUL: begin
                w_mul_a = r_poly;
                w_mul_b = 32'(r_e[15:0]);
                n_state = spce_pkg::S_POLY_USE;
            end
            spce_pkg::S_POLY_USE: begin
                priority if (r_cnt == 4'd0) begin
                    coef = spce_pkg::EXP_B;
                end else if (r_cnt == 4'd1) begin
                    coef = spce_pkg::EXP_A;
                end else begin
                    coef = spce_pkg::ONE_Q30;
                end
                n_poly  = coef + w_prod[47:16];
                n_cnt   = r_cnt + 4'd1;
                n_state = (r_cnt == 4'd2) ? spce_pkg::S_MAG_MUL : spce_pkg::S_POLY_MUL;
            end
            spce_pkg::S_MAG_MUL: begin
                w_mul_a = 32'(ax);
                w_mul_b = r_poly;
                n_state = spce_pkg::S_MAG_RND;
            end
            spce_pkg::S_MAG_RND: begin
                n_acc   = spce_pkg::f_round(w_prod, sh);
                n_state = spce_pkg::S_SAT;
            end
            spce_pkg::S_SAT: begin
                if (x[SB-1]) begin
                    n_y = (r_acc > SAT_HI + 64'd1) ? SB'(SAT_HI + 64'd1) : SB'(-r_acc);
                end else begin
                    n_y = (r_acc > SAT_HI) ? SB'(SAT_HI) : SB'(r_acc);
                end
                n_state = spce_pkg::S_NEXT;
            end
            spce_pkg::S_NEXT: begin
                n_out[r_ch] = r_y;
                if (r_ch == CW'(CH - 1)) begin
                    n_state = spce_pkg::S_DONE;
                end else begin
                    n_ch    = r_ch + CW'(1);
                    n_state = spce_pkg::S_PEAK;
                end
            end
            spce_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = spce_pkg::S_IDLE;
                end
            end
            default: n_state = spce_pkg::S_IDLE;
        endcase
    end

    assign o_idle      = (r_state == spce_pkg::S_IDLE);
    assign o_done      = (r_state == spce_pkg::S_DONE);
    assign o_res.out_a = r_out[0];
    assign o_res.out_b = r_out[1];

endmodule

// File: hdl/stereo_peak_compressor_expander_top.sv
// Stereo peak compressor and expander. Each request carries one Q1.23 sample
// per channel and yields one request with both channels after gain. The two
// channels are worked one after the other through a single shared 32 by 32
// multiplier under a small sequencer. A channel with a quiet envelope skips
// the gain path; on the full gain path the envelope is normalised by shifts
// and the logarithm takes sixteen squaring steps, each with a multiply state
// and a use state. The input is stalled while a request is being worked; a
// finished result waits in the output register, so the next request can
// be taken while it does. The five registers sit at byte addresses 0, 4, 8,
// 12 and 16 and should only be written while the block is idle.
module stereo_peak_compressor_expander_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  spce_pkg::t_in_req   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output spce_pkg::t_out_req  o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    spce_pkg::t_cfg     r_cfg;
    logic               r_out_valid;
    spce_pkg::t_out_req r_out;
    logic               w_idle, w_done, w_take, w_start, w_wr;
    spce_pkg::t_out_req w_res;
    spce_pkg::t_cfg_idx w_idx;

    // The register index is the word address.
    assign w_idx  = spce_pkg::t_cfg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unity_db       <= '0;
            r_cfg.threshold_db   <= -17'sd35840;
            r_cfg.inv_ratio_high <= 23'd65536;
            r_cfg.inv_ratio_low  <= 23'd65536;
            r_cfg.decay_alpha    <= 24'd14800;
        end else if (w_wr) begin
            unique case (w_idx)
                spce_pkg::CFG_UNITY:     r_cfg.unity_db       <= pwdata[15:0];
                spce_pkg::CFG_THRESHOLD: r_cfg.threshold_db   <= pwdata[16:0];
                spce_pkg::CFG_IHIGH:     r_cfg.inv_ratio_high <= pwdata[22:0];
                spce_pkg::CFG_ILOW:      r_cfg.inv_ratio_low  <= pwdata[22:0];
                spce_pkg::CFG_ALPHA:     r_cfg.decay_alpha    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Reads return the raw register bits, zero-extended.
    always_comb begin
        unique case (w_idx)
            spce_pkg::CFG_UNITY:     prdata = 32'({r_cfg.unity_db});
            spce_pkg::CFG_THRESHOLD: prdata = 32'({r_cfg.threshold_db});
            spce_pkg::CFG_IHIGH:     prdata = 32'(r_cfg.inv_ratio_high);
            spce_pkg::CFG_ILOW:      prdata = 32'(r_cfg.inv_ratio_low);
            spce_pkg::CFG_ALPHA:     prdata = 32'(r_cfg.decay_alpha);
            default:                 prdata = '0;
        endcase
    end

    // A new request starts only when the sequencer is idle.
    assign w_start    = i_in_valid && w_idle;
    assign o_in_stall = !w_idle;

    // The finished result moves into the output register when it is empty or
    // being taken in this cycle.
    assign w_take = !r_out_valid || !i_out_stall;

    spce_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_start (w_start),
        .i_req   (i_in),
        .i_take  (w_take),
        .o_idle  (w_idle),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done && w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A request taken in leaves the block busy in the following cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after taking a request");

    // A finished result handed over always shows up at the output.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_take) |=> o_out_valid)
        else $error("finished result not presented");

    // An output taken with nothing new behind it empties the register.
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !w_done) |=> !o_out_valid)
        else $error("output register did not drain");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Checks the stereo peak compressor and expander against a bit-accurate
// predictor held in this module. Each accepted input request advances the
// predictor's own copy of the per-channel envelope and previous sample, and
// the predicted output pair is queued. Every output request taken from the
// block is compared with the oldest queued pair.
module testbench;

    localparam int          PERIOD_NS      = 10;
    localparam int          RESET_CYCLES   = 10;
    localparam int          SETTLE_CYCLES  = 200;
    localparam int          HOLD_CYCLES    = 600;
    localparam int          PHASE_ITEMS    = 104;
    localparam int          NUM_PHASES     = 8;
    localparam int          MAX_REPORTS    = 10;
    localparam longint      CYCLE_LIMIT    = 1500000;
    localparam int          UNUSED_REG_IDX = 5;
    localparam int          NUM_REGS       = 5;
    localparam int          N_DIRECTED     = 18;
    localparam longint      SAT_HI         = 8388607;
    localparam longint      SAT_LO         = -8388608;
    localparam longint      Q16_ONE        = 65536;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    spce_pkg::t_in_req  i_in;
    logic       o_out_valid;
    logic       i_out_stall;
    spce_pkg::t_out_req o_out;
    logic       psel;
    logic       penable;
    logic       pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic       pready;

    stereo_peak_compressor_expander_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Predictor state: shared settings and the per-channel history.
    spce_pkg::t_cfg gain_cfg;
    logic [23:0] prev_smp [spce_pkg::CHANNELS];
    logic [31:0] env_lvl  [spce_pkg::CHANNELS];

    // Output pairs that the block still owes us, oldest first.
    spce_pkg::t_out_req pending_out [$];

    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          reg_writes;
    longint      cycles;
    int          stall_pct;
    bit          hold_req;
    int          hold_left;
    bit          bursty;

    // Directed stimulus. Where both samples are zero the output pair must be
    // zero whatever the envelope is, so that row carries its answer.
    typedef struct {
        logic signed [23:0] a;
        logic signed [23:0] b;
        bit                 known;
        logic signed [23:0] ea;
        logic signed [23:0] eb;
    } t_row;

    t_row directed_rows [N_DIRECTED];

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(PERIOD_NS / 2) i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Rounds a * b / 2^sh half away from zero.
    function automatic longint round_mul(input longint a, input longint unsigned b,
                                         input int sh);
        longint unsigned mag;
        longint unsigned m;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        m = (mag * b + (64'd1 << (sh - 1))) >> sh;
        return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    // log2 of env / 2^31 in Q16, by normalising and then squaring sixteen times.
    function automatic longint env_log2(input logic [31:0] env);
        int              k;
        longint unsigned m;
        longint          frac;
        k = 31;
        frac = 0;
        while (k > 0 && !env[k])
            k--;
        m = longint'(env) << (31 - k);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(k - 31) * Q16_ONE + frac;
    endfunction

    // Scales x by 2^(e / 2^16), rounds and saturates to the sample width.
    function automatic logic signed [23:0] scale_sample(input longint x, input longint e);
        longint          ip;
        longint          s;
        longint unsigned f;
        longint unsigned p;
        longint unsigned m;
        longint unsigned mag;
        if (x == 0)
            return '0;
        if (e >= 24 * Q16_ONE)
            return (x < 0) ? SAT_LO[23:0] : SAT_HI[23:0];
        if (e < -32 * Q16_ONE)
            e = -32 * Q16_ONE;
        if (e >= 0)
            ip = e / Q16_ONE;
        else
            ip = -((-e + Q16_ONE - 1) / Q16_ONE);
        f = e - ip * Q16_ONE;
        p = spce_pkg::EXP_C;
        p = spce_pkg::EXP_B + ((p * f) >> 16);
        p = spce_pkg::EXP_A + ((p * f) >> 16);
        p = spce_pkg::ONE_Q30 + ((p * f) >> 16);
        mag = (x < 0) ? longint'(-x) : longint'(x);
        m = mag * p;
        s = 30 - ip;
        if (s > 0)
            m = (m + (64'd1 << (s - 1))) >> s;
        else
            m = m << (-s);
        if (x < 0)
            return (m > longint'(SAT_HI) + 1) ? SAT_LO[23:0] : 24'(-longint'(m));
        return (m > longint'(SAT_HI)) ? SAT_HI[23:0] : 24'(m);
    endfunction

    // One step of the compressor for both channels; updates the history.
    function automatic spce_pkg::t_out_req compress_pair(input spce_pkg::t_in_req req);
        spce_pkg::t_out_req res;
        logic [23:0]     smp [spce_pkg::CHANNELS];
        logic [23:0]     ys  [spce_pkg::CHANNELS];
        longint          x, pv, un, thr, db_in, g;
        longint unsigned peak, peak2, env;
        un  = gain_cfg.unity_db;
        thr = gain_cfg.threshold_db;
        smp[0] = req.sample_a;
        smp[1] = req.sample_b;
        for (int c = 0; c < spce_pkg::CHANNELS; c++) begin
            x  = $signed(smp[c]);
            pv = $signed(prev_smp[c]);
            peak  = ((x < 0) ? longint'(-x) : longint'(x)) << spce_pkg::ENV_SHIFT;
            peak2 = (((x + pv < 0) ? longint'(-(x + pv)) : longint'(x + pv))
                     << spce_pkg::ENV_SHIFT) >> 1;
            env = env_lvl[c];
            if (peak2 > peak)
                peak = peak2;
            if (peak > env)
                env = peak;
            else
                env = env - (((env - peak) * longint'(gain_cfg.decay_alpha)) >> 24);
            env_lvl[c]  = env[31:0];
            prev_smp[c] = smp[c];
            ys[c] = '0;
            if (env >= (64'd1 << spce_pkg::ENV_SHIFT)) begin
                db_in = round_mul(env_log2(env[31:0]), spce_pkg::DB_PER_LOG2, 24);
                if (db_in <= thr)
                    g = un + round_mul(thr - un, gain_cfg.inv_ratio_high, 16)
                           + round_mul(db_in - thr, gain_cfg.inv_ratio_low, 16) - db_in;
                else
                    g = un + round_mul(db_in - un, gain_cfg.inv_ratio_high, 16) - db_in;
                ys[c] = scale_sample(x, round_mul(g, spce_pkg::LOG2_PER_DB, 16));
            end
        end
        res.out_a = ys[0];
        res.out_b = ys[1];
        return res;
    endfunction

    // Mirrors a register write in the predictor; unknown indexes are ignored.
    function automatic void shadow_reg(input int idx, input logic [31:0] v);
        case (idx)
            spce_pkg::CFG_UNITY:     gain_cfg.unity_db       = v[15:0];
            spce_pkg::CFG_THRESHOLD: gain_cfg.threshold_db   = v[16:0];
            spce_pkg::CFG_IHIGH:     gain_cfg.inv_ratio_high = v[22:0];
            spce_pkg::CFG_ILOW:      gain_cfg.inv_ratio_low  = v[22:0];
            spce_pkg::CFG_ALPHA:     gain_cfg.decay_alpha    = v[23:0];
            default: begin
            end
        endcase
    endfunction

    // Register write: a setup phase, then an access phase held until pready.
    task automatic write_reg(input int idx, input logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 5'(4 * idx);
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        shadow_reg(idx, v);
        reg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one request and holds it until the block takes it. A known
    // answer, where given, replaces the predicted one in the queue, though
    // the predictor still steps so its history stays in line.
    task automatic offer_pair(input spce_pkg::t_in_req req, input bit known,
                              input spce_pkg::t_out_req ans);
        spce_pkg::t_out_req pred;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pred = compress_pair(req);
        pending_out.push_back(known ? ans : pred);
        items_sent++;
    endtask

    task automatic go_quiet(input int gap);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (gap - 1)
            @(negedge i_clk);
    endtask

    // Lets every owed result arrive, then allows for work still in flight.
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    // Mixture of full-range noise, small levels that exercise the quiet end of
    // the curves, exact extremes, silence, sign flips and slowly moving signals.
    function automatic logic signed [23:0] pick_sample(input logic signed [23:0] last);
        logic [23:0] mag;
        int          sh;
        case ($urandom_range(9))
            0, 1, 2, 3: return 24'($urandom);
            4, 5: begin
                sh  = $urandom_range(22);
                mag = 24'($urandom) & ((24'd1 << sh) - 24'd1);
                return $urandom_range(1) ? -$signed(mag) : $signed(mag);
            end
            6: begin
                case ($urandom_range(4))
                    0: return SAT_HI[23:0];
                    1: return SAT_LO[23:0];
                    2: return 24'sd1;
                    3: return -24'sd1;
                    default: return '0;
                endcase
            end
            7: return '0;
            8: return -last;
            default: return last + $signed(24'($urandom_range(2000)) - 24'd1000);
        endcase
    endfunction

    // Output side: stalls on its own random pattern, with one long hold-off
    // on request so that the block fills and pushes back on its input.
    initial begin
        i_out_stall = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Result checker, sampling at the rising edge.
    always @(posedge i_clk) begin
        spce_pkg::t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_out.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output request a=%0d b=%0d",
                             o_out.out_a, o_out.out_b);
            end else begin
                want = pending_out.pop_front();
                if (o_out.out_a !== want.out_a || o_out.out_b !== want.out_b) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch at result %0d: expected a=%0d b=%0d, got a=%0d b=%0d",
                                 results_seen, want.out_a, want.out_b,
                                 o_out.out_a, o_out.out_b);
                end
            end
        end
    end

    initial begin
        spce_pkg::t_in_req  req;
        spce_pkg::t_out_req ans;
        logic [31:0] regv [NUM_PHASES][NUM_REGS];
        logic signed [23:0] last_a, last_b;
        int          burst;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        stall_pct  = 0;
        hold_req   = 1'b0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        reg_writes = 0;

        // Predictor starts from the block's reset state.
        gain_cfg.unity_db       = 16'sd0;
        gain_cfg.threshold_db   = -17'sd35840;
        gain_cfg.inv_ratio_high = 23'd65536;
        gain_cfg.inv_ratio_low  = 23'd65536;
        gain_cfg.decay_alpha    = 24'd14800;
        for (int c = 0; c < spce_pkg::CHANNELS; c++) begin
            prev_smp[c] = '0;
            env_lvl[c]  = '0;
        end

        directed_rows = '{
            '{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
            '{24'sh7FFFFF, -24'sh800000, 1'b0, 24'sd0, 24'sd0},
            '{-24'sh800000, 24'sh7FFFFF, 1'b0, 24'sd0, 24'sd0},
            '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 24'sd0, 24'sd0},
            '{-24'sh800000, -24'sh800000, 1'b0, 24'sd0, 24'sd0},
            '{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
            '{24'sd1, -24'sd1, 1'b0, 24'sd0, 24'sd0},
            '{-24'sd1, 24'sd1, 1'b0, 24'sd0, 24'sd0},
            '{24'sh400000, -24'sh400000, 1'b0, 24'sd0, 24'sd0},
            '{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
            '{24'sh7FFFFF, -24'sh7FFFFF, 1'b0, 24'sd0, 24'sd0},
            '{24'sd123456, -24'sd654321, 1'b0, 24'sd0, 24'sd0},
            '{24'sd256, -24'sd256, 1'b0, 24'sd0, 24'sd0},
            '{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
            '{24'sd1000, -24'sd1000, 1'b0, 24'sd0, 24'sd0},
            '{-24'sd1000, 24'sd1000, 1'b0, 24'sd0, 24'sd0},
            '{24'sh555555, 24'sh2AAAAA, 1'b0, 24'sd0, 24'sd0},
            '{-24'sh555556, -24'sh2AAAAB, 1'b0, 24'sd0, 24'sd0}
        };

        // Settings for each random phase: the low ends of every range, the
        // high ends, zero slopes, every register bit set, then random ones.
        regv[0] = '{32'hFFFF_A000, 32'hFFFF_7400, 32'd655, 32'd655, 32'd0};
        regv[1] = '{32'd0, 32'd0, 32'd6553600, 32'd6553600, 32'd16777215};
        regv[2] = '{32'd0, 32'hFFFF_7400, 32'd0, 32'd0, 32'd14800};
        regv[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF};
        for (int p = 4; p < NUM_PHASES; p++) begin
            regv[p][spce_pkg::CFG_UNITY]     = 32'(-$signed(32'($urandom_range(24576))));
            regv[p][spce_pkg::CFG_THRESHOLD] = 32'(-$signed(32'($urandom_range(35840))));
            regv[p][spce_pkg::CFG_IHIGH]     = $urandom_range(6553600, 655);
            regv[p][spce_pkg::CFG_ILOW]      = $urandom_range(6553600, 655);
            regv[p][spce_pkg::CFG_ALPHA]     = $urandom_range(16777215);
        end

        repeat (RESET_CYCLES)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset settings, back to back.
        foreach (directed_rows[i]) begin
            req.sample_a = directed_rows[i].a;
            req.sample_b = directed_rows[i].b;
            ans.out_a    = directed_rows[i].ea;
            ans.out_b    = directed_rows[i].eb;
            offer_pair(req, directed_rows[i].known, ans);
        end
        drain();

        last_a = '0;
        last_b = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int r = 0; r < NUM_REGS; r++)
                write_reg(r, regv[p][r]);
            // A write past the last register must leave the settings alone.
            if (p == 0)
                write_reg(UNUSED_REG_IDX, $urandom);

            stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 30 : 75;
            bursty    = (p != 1);
            if (p == 4)
                hold_req = 1'b1;
            burst = $urandom_range(20, 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                req.sample_a = pick_sample(last_a);
                req.sample_b = pick_sample(last_b);
                last_a = req.sample_a;
                last_b = req.sample_b;
                offer_pair(req, 1'b0, ans);
                if (bursty && --burst == 0) begin
                    go_quiet($urandom_range(12, 1));
                    burst = $urandom_range(20, 1);
                end
            end
            drain();
        end

        $display("Covered %0d input requests and %0d output requests over %0d phases",
                 items_sent, results_seen, NUM_PHASES + 1);
        $display("with %0d register writes, including both ends of every range.", reg_writes);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
